FILE: sv/cec_pkg.sv
package cec_pkg;

	// Field widths
	localparam int CEC_DIST_W = 13;
	localparam int CEC_AVG_W  = CEC_DIST_W + 8;
	localparam int CEC_TIME_W = 32;
	localparam int CEC_MS_W   = 16;
	localparam int CEC_CNT_W  = 8;
	localparam int CEC_PWM_W  = 8;
	localparam int CEC_CFG_W  = 16;
	localparam int CEC_IDX_W  = 3;

	// Saturation limit of the steering repeat counter
	localparam int CEC_HOLD_COUNT_MAX = 255;

	// Exponential average weights, Q8
	localparam logic [7:0] CEC_ALPHA_Q8   = 8'd77;
	localparam logic [7:0] CEC_ALPHA_REST = 8'd179;

	// Idle wait before exploring starts
	localparam logic [CEC_TIME_W-1:0] CEC_IDLE_WAIT_MS = 32'd2000;

	// Motor levels in percent
	localparam logic signed [CEC_PWM_W-1:0] CEC_PWM_EXPLORE = 8'sd70;
	localparam logic signed [CEC_PWM_W-1:0] CEC_PWM_SLOW    = 8'sd45;
	localparam logic signed [CEC_PWM_W-1:0] CEC_PWM_REVERSE = -8'sd50;
	localparam logic signed [CEC_PWM_W-1:0] CEC_PWM_OFF     = 8'sd0;

	// Register reset values
	localparam logic [CEC_DIST_W-1:0] CEC_RST_FRONT_STOP = 13'd192;
	localparam logic [CEC_DIST_W-1:0] CEC_RST_FRONT_SLOW = 13'd320;
	localparam logic [CEC_DIST_W-1:0] CEC_RST_SIDE_MIN   = 13'd96;
	localparam logic [CEC_DIST_W-1:0] CEC_RST_DEADBAND   = 13'd48;
	localparam logic [CEC_CNT_W-1:0]  CEC_RST_STEER_HOLD = 8'd3;
	localparam logic [CEC_MS_W-1:0]   CEC_RST_REVERSE_MS = 16'd1000;
	localparam logic [CEC_MS_W-1:0]   CEC_RST_TURN_MS    = 16'd1500;
	localparam logic [CEC_MS_W-1:0]   CEC_RST_STUCK_MS   = 16'd3000;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_EXPLORE = 2'd1,
		MODE_RECOVER = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STEER_LEFT     = 2'd0,
		STEER_STRAIGHT = 2'd1,
		STEER_RIGHT    = 2'd2
	} steer_t;

	typedef enum logic [CEC_IDX_W-1:0] {
		CFG_FRONT_STOP = 3'd0,
		CFG_FRONT_SLOW = 3'd1,
		CFG_SIDE_MIN   = 3'd2,
		CFG_DEADBAND   = 3'd3,
		CFG_STEER_HOLD = 3'd4,
		CFG_REVERSE_MS = 3'd5,
		CFG_TURN_MS    = 3'd6,
		CFG_STUCK_MS   = 3'd7
	} cfg_idx_t;

endpackage

FILE: sv/cec_smooth.sv
module cec_smooth (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic                            sample_valid,
	input  logic [cec_pkg::CEC_DIST_W-1:0]  sample,
	output logic [cec_pkg::CEC_AVG_W-1:0]   avg_next,
	output logic                            known_next
);
	import cec_pkg::*;

	logic [CEC_AVG_W-1:0]   avg_q;
	logic                   known_q;
	logic [CEC_AVG_W-1:0]   new_term;
	logic [CEC_AVG_W+7:0]   old_prod;

	// New sample weighted by alpha; the old average by one minus alpha.
	// The sample term, the Q8 sample times alpha over 256, is just the sample times
	// alpha, so only the old term needs the truncating shift.
	assign new_term = CEC_AVG_W'(sample) * CEC_AVG_W'(CEC_ALPHA_Q8);
	assign old_prod = (CEC_AVG_W+8)'(avg_q) * (CEC_AVG_W+8)'(CEC_ALPHA_REST);

	// The first real sample loads directly; a missing sample keeps the average.
	always_comb begin
		if (!sample_valid) begin
			avg_next = avg_q;
		end else if (!known_q) begin
			avg_next = {sample, 8'b0};
		end else begin
			avg_next = new_term + old_prod[CEC_AVG_W+7:8];
		end
	end

	assign known_next = known_q | sample_valid;

	// The average itself is only read once the known flag is set.
	always_ff @(posedge clk) begin
		if (load) begin
			avg_q <= avg_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= 1'b0;
		end else if (load) begin
			known_q <= known_next;
		end
	end

endmodule

FILE: sv/corridor_explore_controller_unit.sv
// Corridor exploration controller: one control tick in, one motor command out.
// Input channel: in_valid / in_stall carry one tick beat with the three
// ultrasonic distances, their valid flags and a millisecond time stamp.
// Output channel: out_valid / out_stall carry one result beat per tick with the
// signed motor percent, the steering command and the mode after the tick.
// Configuration: cfg_write_enable writes cfg_data into the register picked by
// cfg_index on the same edge; write only while no tick is in flight.
// Path: a beat taken sits in the input register, and its result is registered
// in the result register once that register is free or being taken.
// Throughput: one tick per cycle unless the receiver stalls; the filter, mode and
// steering update for a tick is a single pass of logic between the input and
// result registers, and the state it writes is ready for the next tick.
// While the receiver stalls, the result holds and one further beat waits in
// the input register; in_stall rises only when both are full.
// Reset clears the averages' known flags, puts the mode in idle, straight
// steering, zero repeat count, no blockage, and all config registers to their
// defaults. Idle turns into explore on the first tick later than 2000 ms.
module corridor_explore_controller_unit #(
	parameter int HOLD_COUNT_MAX = cec_pkg::CEC_HOLD_COUNT_MAX
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_write_enable,
	input  logic [cec_pkg::CEC_IDX_W-1:0]         cfg_index,
	input  logic [cec_pkg::CEC_CFG_W-1:0]         cfg_data,
	// Input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cec_pkg::CEC_DIST_W-1:0]        left_distance,
	input  logic [cec_pkg::CEC_DIST_W-1:0]        right_distance,
	input  logic [cec_pkg::CEC_DIST_W-1:0]        front_distance,
	input  logic                                  left_valid,
	input  logic                                  right_valid,
	input  logic                                  front_valid,
	input  logic [cec_pkg::CEC_TIME_W-1:0]        time_ms,
	// Output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cec_pkg::CEC_PWM_W-1:0]  motor_drive,
	output logic [1:0]                            steer_command,
	output logic [1:0]                            mode_now
);
	import cec_pkg::*;

	// Configuration registers
	logic [CEC_DIST_W-1:0] front_stop_q, front_slow_q, side_min_q, deadband_q;
	logic [CEC_CNT_W-1:0]  steer_hold_q;
	logic [CEC_MS_W-1:0]   reverse_ms_q, turn_ms_q, stuck_ms_q;

	// Input stage
	logic                  valid_s1;
	logic [CEC_DIST_W-1:0] left_s1, right_s1, front_s1;
	logic                  left_valid_s1, right_valid_s1, front_valid_s1;
	logic [CEC_TIME_W-1:0] time_s1;

	// Controller state
	mode_t                 mode_q;
	logic [CEC_TIME_W-1:0] blocked_since_q, recover_start_q;
	steer_t                last_req_q, applied_q;
	logic [CEC_CNT_W-1:0]  same_count_q;

	// Result register
	logic                  out_valid_q;
	logic signed [CEC_PWM_W-1:0] motor_q;
	steer_t                steer_q;
	mode_t                 mode_out_q;

	// Handshake
	logic                  in_take;
	logic                  advance;

	// Update logic
	logic [CEC_AVG_W-1:0]  avg_left, avg_right, avg_front;
	logic                  known_left, known_right, known_front;
	logic                  front_stop, front_slow, left_tight, right_tight, both_sides;
	steer_t                away_steer;
	logic signed [CEC_AVG_W:0] center_err, band;
	mode_t                 mode_start, mode_next;
	logic [CEC_TIME_W-1:0] blocked_next, recover_next, recover_dt;
	logic [CEC_MS_W:0]     recover_total;
	steer_t                request, last_req_next, applied_next, steer_next;
	logic [CEC_CNT_W-1:0]  same_count_next;
	logic                  hyst_en;
	logic signed [CEC_PWM_W-1:0] motor_next, explore_pwm;

	// The input register drains whenever the result register is free or taken.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration writes; each value is cut to its register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_stop_q <= CEC_RST_FRONT_STOP;
			front_slow_q <= CEC_RST_FRONT_SLOW;
			side_min_q   <= CEC_RST_SIDE_MIN;
			deadband_q   <= CEC_RST_DEADBAND;
			steer_hold_q <= CEC_RST_STEER_HOLD;
			reverse_ms_q <= CEC_RST_REVERSE_MS;
			turn_ms_q    <= CEC_RST_TURN_MS;
			stuck_ms_q   <= CEC_RST_STUCK_MS;
		end else if (cfg_write_enable) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRONT_STOP: front_stop_q <= cfg_data[CEC_DIST_W-1:0];
				CFG_FRONT_SLOW: front_slow_q <= cfg_data[CEC_DIST_W-1:0];
				CFG_SIDE_MIN:   side_min_q   <= cfg_data[CEC_DIST_W-1:0];
				CFG_DEADBAND:   deadband_q   <= cfg_data[CEC_DIST_W-1:0];
				CFG_STEER_HOLD: steer_hold_q <= cfg_data[CEC_CNT_W-1:0];
				CFG_REVERSE_MS: reverse_ms_q <= cfg_data[CEC_MS_W-1:0];
				CFG_TURN_MS:    turn_ms_q    <= cfg_data[CEC_MS_W-1:0];
				CFG_STUCK_MS:   stuck_ms_q   <= cfg_data[CEC_MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			left_s1        <= left_distance;
			right_s1       <= right_distance;
			front_s1       <= front_distance;
			left_valid_s1  <= left_valid;
			right_valid_s1 <= right_valid;
			front_valid_s1 <= front_valid;
			time_s1        <= time_ms;
		end
	end

	// One exponential average per sensor.
	cec_smooth u_smooth_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.sample_valid (left_valid_s1),
		.sample       (left_s1),
		.avg_next     (avg_left),
		.known_next   (known_left)
	);

	cec_smooth u_smooth_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.sample_valid (right_valid_s1),
		.sample       (right_s1),
		.avg_next     (avg_right),
		.known_next   (known_right)
	);

	cec_smooth u_smooth_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.sample_valid (front_valid_s1),
		.sample       (front_s1),
		.avg_next     (avg_front),
		.known_next   (known_front)
	);

	// Threshold tests on the fresh averages; an unknown distance never passes.
	assign front_stop  = known_front && (avg_front < {front_stop_q, 8'b0});
	assign front_slow  = known_front && (avg_front < {front_slow_q, 8'b0});
	assign left_tight  = known_left  && (avg_left  < {side_min_q, 8'b0});
	assign right_tight = known_right && (avg_right < {side_min_q, 8'b0});
	assign both_sides  = known_left && known_right;
	assign away_steer  = (both_sides && (avg_left < avg_right)) ? STEER_RIGHT : STEER_LEFT;

	// Centering error, right minus left, against the deadband.
	assign center_err = $signed({1'b0, avg_right}) - $signed({1'b0, avg_left});
	assign band       = $signed({1'b0, deadband_q, 8'b0});

	// Recovery phase timing.
	assign recover_dt    = time_s1 - recover_next;
	assign recover_total = {1'b0, reverse_ms_q} + {1'b0, turn_ms_q};

	// Mode, blockage and command for one tick.
	always_comb begin
		mode_start   = mode_q;
		blocked_next = blocked_since_q;
		recover_next = recover_start_q;

		if (mode_q == MODE_IDLE && time_s1 > CEC_IDLE_WAIT_MS) begin
			mode_start = MODE_EXPLORE;
		end
		mode_next = mode_start;

		// Blockage tracking; a stamp of zero means not blocked.
		if (mode_start == MODE_EXPLORE) begin
			if (front_stop) begin
				if (blocked_since_q == '0) begin
					blocked_next = time_s1;
				end else if ((time_s1 - blocked_since_q) > CEC_TIME_W'(stuck_ms_q)) begin
					mode_next    = MODE_RECOVER;
					recover_next = time_s1;
				end
			end else begin
				blocked_next = '0;
			end
		end

		// Steering request in explore.
		request     = STEER_STRAIGHT;
		explore_pwm = front_slow ? CEC_PWM_SLOW : CEC_PWM_EXPLORE;
		if (both_sides) begin
			if (center_err > band) begin
				request = STEER_RIGHT;
			end else if (center_err < -band) begin
				request = STEER_LEFT;
			end
		end
		if (left_tight) begin
			request     = STEER_RIGHT;
			explore_pwm = CEC_PWM_SLOW;
		end
		if (right_tight) begin
			request     = STEER_LEFT;
			explore_pwm = CEC_PWM_SLOW;
		end

		// Repeat-count hysteresis.
		if (request == last_req_q) begin
			last_req_next   = last_req_q;
			same_count_next = (same_count_q < CEC_CNT_W'(HOLD_COUNT_MAX)) ?
				same_count_q + CEC_CNT_W'(1) : same_count_q;
		end else begin
			last_req_next   = request;
			same_count_next = CEC_CNT_W'(1);
		end
		applied_next = (same_count_next >= steer_hold_q) ? request : applied_q;

		hyst_en    = 1'b0;
		motor_next = CEC_PWM_OFF;
		steer_next = STEER_STRAIGHT;
		case (mode_next)
			MODE_EXPLORE: begin
				if (front_stop) begin
					steer_next = away_steer;
				end else begin
					hyst_en    = 1'b1;
					motor_next = explore_pwm;
					steer_next = applied_next;
				end
			end
			MODE_RECOVER: begin
				if (recover_dt < CEC_TIME_W'(reverse_ms_q)) begin
					motor_next = CEC_PWM_REVERSE;
				end else if (recover_dt < CEC_TIME_W'(recover_total)) begin
					motor_next = CEC_PWM_SLOW;
					steer_next = away_steer;
				end else begin
					mode_next  = MODE_EXPLORE;
					motor_next = CEC_PWM_SLOW;
				end
			end
			MODE_IDLE, MODE_STOP: begin
				motor_next = CEC_PWM_OFF;
			end
			default: begin
				motor_next = CEC_PWM_OFF;
			end
		endcase
	end

	// Controller state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_IDLE;
			blocked_since_q <= '0;
			recover_start_q <= '0;
			last_req_q      <= STEER_STRAIGHT;
			applied_q       <= STEER_STRAIGHT;
			same_count_q    <= '0;
		end else if (advance) begin
			mode_q          <= mode_next;
			blocked_since_q <= blocked_next;
			recover_start_q <= recover_next;
			if (hyst_en) begin
				last_req_q   <= last_req_next;
				applied_q    <= applied_next;
				same_count_q <= same_count_next;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			motor_q    <= motor_next;
			steer_q    <= steer_next;
			mode_out_q <= mode_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_drive   = motor_q;
	assign steer_command = steer_q;
	assign mode_now      = mode_out_q;

	// The stop mode is never entered.
	a_no_stop_mode: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_STOP)
		else $error("controller entered the stop mode");

	// Reverse drive only happens while recovering.
	a_reverse_in_recover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (motor_q == CEC_PWM_REVERSE) |-> mode_out_q == MODE_RECOVER)
		else $error("reverse drive outside recovery");

	// The repeat counter never passes its saturation limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		same_count_q <= CEC_CNT_W'(HOLD_COUNT_MAX))
		else $error("steering repeat count above its limit");

	// A tick held in the input register is produced once the result is taken.
	a_drain_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_stall |=> out_valid_q)
		else $error("waiting tick not moved to the result register");

endmodule

FILE: tb/corridor_explore_controller_unit_test.sv
module corridor_explore_controller_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cec_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int TICKS_PER_PHASE = 204;
	localparam int NUM_PHASES      = 8;

	// Controller constants used by the predictor
	localparam logic [7:0]  AVG_NEW_Q8   = 8'd77;
	localparam logic [7:0]  AVG_OLD_Q8   = 8'd179;
	localparam logic [31:0] IDLE_WAIT    = 32'd2000;
	localparam logic [7:0]  REPEAT_SAT   = 8'd255;
	localparam logic signed [7:0] PWM_CRUISE  = 8'sd70;
	localparam logic signed [7:0] PWM_CAREFUL = 8'sd45;
	localparam logic signed [7:0] PWM_BACK    = -8'sd50;
	localparam logic signed [7:0] PWM_HALT    = 8'sd0;

	typedef struct packed {
		logic [CEC_DIST_W-1:0] left;
		logic [CEC_DIST_W-1:0] right;
		logic [CEC_DIST_W-1:0] front;
		logic                  left_ok;
		logic                  right_ok;
		logic                  front_ok;
		logic [CEC_TIME_W-1:0] ms;
	} tick_t;

	typedef struct packed {
		logic signed [CEC_PWM_W-1:0] motor;
		steer_t                      steer;
		mode_t                       mode;
	} drive_cmd_t;

	typedef struct packed {
		tick_t      t;
		logic       fixed_want;
		drive_cmd_t want;
	} dir_row_t;

	typedef struct {
		logic [CEC_DIST_W-1:0] front_stop;
		logic [CEC_DIST_W-1:0] front_slow;
		logic [CEC_DIST_W-1:0] side_min;
		logic [CEC_DIST_W-1:0] deadband;
		logic [CEC_CNT_W-1:0]  hold;
		logic [CEC_MS_W-1:0]   reverse_ms;
		logic [CEC_MS_W-1:0]   turn_ms;
		logic [CEC_MS_W-1:0]   stuck_ms;
	} ctrl_cfg_t;

	typedef struct {
		logic [CEC_AVG_W-1:0]  avg_left;
		logic [CEC_AVG_W-1:0]  avg_right;
		logic [CEC_AVG_W-1:0]  avg_front;
		logic                  known_left;
		logic                  known_right;
		logic                  known_front;
		mode_t                 mode;
		logic [CEC_TIME_W-1:0] blocked_since;
		logic [CEC_TIME_W-1:0] recover_start;
		steer_t                last_req;
		steer_t                applied;
		logic [CEC_CNT_W-1:0]  repeat_count;
	} ctrl_state_t;

	localparam drive_cmd_t IDLE_CMD = '{PWM_HALT, STEER_STRAIGHT, MODE_IDLE};

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write_enable = 1'b0;
	logic [CEC_IDX_W-1:0] cfg_index = '0;
	logic [CEC_CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CEC_DIST_W-1:0] left_distance = '0;
	logic [CEC_DIST_W-1:0] right_distance = '0;
	logic [CEC_DIST_W-1:0] front_distance = '0;
	logic left_valid = 1'b0;
	logic right_valid = 1'b0;
	logic front_valid = 1'b0;
	logic [CEC_TIME_W-1:0] time_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CEC_PWM_W-1:0] motor_drive;
	logic [1:0] steer_command;
	logic [1:0] mode_now;

	ctrl_cfg_t   cfg;
	ctrl_state_t ctl;
	drive_cmd_t  pending_cmds[$];
	dir_row_t    directed_rows[25];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_asked = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;

	corridor_explore_controller_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.left_distance    (left_distance),
		.right_distance   (right_distance),
		.front_distance   (front_distance),
		.left_valid       (left_valid),
		.right_valid      (right_valid),
		.front_valid      (front_valid),
		.time_ms          (time_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.motor_drive      (motor_drive),
		.steer_command    (steer_command),
		.mode_now         (mode_now)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Exponential average in Q8; the first real sample loads directly.
	function automatic logic [CEC_AVG_W-1:0] smooth_step(logic [CEC_AVG_W-1:0] avg,
			logic seen, logic [CEC_DIST_W-1:0] x);
		logic [31:0] acc;
		if (!seen)
			return {x, 8'd0};
		acc = 32'(AVG_NEW_Q8) * {11'd0, x, 8'd0} + 32'(AVG_OLD_Q8) * {11'd0, avg};
		return acc[28:8];
	endfunction

	// A distance that has never been valid fails every threshold test.
	function automatic logic closer_than(logic [CEC_AVG_W-1:0] avg, logic seen,
			logic [CEC_DIST_W-1:0] limit);
		return seen && (avg < {limit, 8'd0});
	endfunction

	function automatic steer_t turn_away();
		if (ctl.known_left && ctl.known_right && ctl.avg_left < ctl.avg_right)
			return STEER_RIGHT;
		return STEER_LEFT;
	endfunction

	// Advances the controller state by one tick and returns its command.
	function automatic drive_cmd_t predict_command(tick_t t);
		drive_cmd_t cmd;
		steer_t req;
		logic [31:0] dt;
		logic signed [22:0] err;
		logic signed [22:0] band;
		cmd = IDLE_CMD;
		if (t.left_ok) begin
			ctl.avg_left = smooth_step(ctl.avg_left, ctl.known_left, t.left);
			ctl.known_left = 1'b1;
		end
		if (t.right_ok) begin
			ctl.avg_right = smooth_step(ctl.avg_right, ctl.known_right, t.right);
			ctl.known_right = 1'b1;
		end
		if (t.front_ok) begin
			ctl.avg_front = smooth_step(ctl.avg_front, ctl.known_front, t.front);
			ctl.known_front = 1'b1;
		end

		if (ctl.mode == MODE_IDLE && t.ms > IDLE_WAIT)
			ctl.mode = MODE_EXPLORE;

		// Blockage timer: zero means not blocked, so a block at time zero rearms.
		if (ctl.mode == MODE_EXPLORE) begin
			if (closer_than(ctl.avg_front, ctl.known_front, cfg.front_stop)) begin
				if (ctl.blocked_since == '0) begin
					ctl.blocked_since = t.ms;
				end else if (t.ms - ctl.blocked_since > {16'd0, cfg.stuck_ms}) begin
					ctl.mode = MODE_RECOVER;
					ctl.recover_start = t.ms;
				end
			end else begin
				ctl.blocked_since = '0;
			end
		end

		case (ctl.mode)
			MODE_EXPLORE: begin
				if (closer_than(ctl.avg_front, ctl.known_front, cfg.front_stop)) begin
					cmd.motor = PWM_HALT;
					cmd.steer = turn_away();
				end else begin
					cmd.motor = PWM_CRUISE;
					req = STEER_STRAIGHT;
					if (closer_than(ctl.avg_front, ctl.known_front, cfg.front_slow))
						cmd.motor = PWM_CAREFUL;
					if (ctl.known_left && ctl.known_right) begin
						err = $signed({2'b00, ctl.avg_right}) - $signed({2'b00, ctl.avg_left});
						band = $signed({2'b00, cfg.deadband, 8'd0});
						if (err > band)
							req = STEER_RIGHT;
						else if (err < -band)
							req = STEER_LEFT;
					end
					if (closer_than(ctl.avg_left, ctl.known_left, cfg.side_min)) begin
						req = STEER_RIGHT;
						cmd.motor = PWM_CAREFUL;
					end
					if (closer_than(ctl.avg_right, ctl.known_right, cfg.side_min)) begin
						req = STEER_LEFT;
						cmd.motor = PWM_CAREFUL;
					end
					// Steering only follows a request after enough repeats.
					if (req == ctl.last_req) begin
						if (ctl.repeat_count != REPEAT_SAT)
							ctl.repeat_count = ctl.repeat_count + 8'd1;
					end else begin
						ctl.last_req = req;
						ctl.repeat_count = 8'd1;
					end
					if (ctl.repeat_count >= cfg.hold)
						ctl.applied = req;
					cmd.steer = ctl.applied;
				end
			end
			MODE_RECOVER: begin
				dt = t.ms - ctl.recover_start;
				if (dt < {16'd0, cfg.reverse_ms}) begin
					cmd.motor = PWM_BACK;
					cmd.steer = STEER_STRAIGHT;
				end else if (dt < {16'd0, cfg.reverse_ms} + {16'd0, cfg.turn_ms}) begin
					cmd.motor = PWM_CAREFUL;
					cmd.steer = turn_away();
				end else begin
					ctl.mode = MODE_EXPLORE;
					cmd.motor = PWM_CAREFUL;
					cmd.steer = STEER_STRAIGHT;
				end
			end
			default: begin
				cmd.motor = PWM_HALT;
				cmd.steer = STEER_STRAIGHT;
			end
		endcase
		cmd.mode = ctl.mode;
		return cmd;
	endfunction

	// A sensor reading scattered a little around a target distance.
	function automatic logic [CEC_DIST_W-1:0] near_value(int base);
		int v;
		v = base + int'($urandom_range(0, 40)) - 20;
		if (v < 0)
			v = 0;
		if (v > 8191)
			v = 8191;
		return v[CEC_DIST_W-1:0];
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CEC_CFG_W-1:0] val);
		cfg_write_enable <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_FRONT_STOP: cfg.front_stop = val[CEC_DIST_W-1:0];
			CFG_FRONT_SLOW: cfg.front_slow = val[CEC_DIST_W-1:0];
			CFG_SIDE_MIN:   cfg.side_min = val[CEC_DIST_W-1:0];
			CFG_DEADBAND:   cfg.deadband = val[CEC_DIST_W-1:0];
			CFG_STEER_HOLD: cfg.hold = val[CEC_CNT_W-1:0];
			CFG_REVERSE_MS: cfg.reverse_ms = val;
			CFG_TURN_MS:    cfg.turn_ms = val;
			CFG_STUCK_MS:   cfg.stuck_ms = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] stop, input logic [15:0] slow,
			input logic [15:0] side, input logic [15:0] band, input logic [15:0] hold,
			input logic [15:0] rev, input logic [15:0] turn, input logic [15:0] stuck);
		write_reg(CFG_FRONT_STOP, stop);
		write_reg(CFG_FRONT_SLOW, slow);
		write_reg(CFG_SIDE_MIN, side);
		write_reg(CFG_DEADBAND, band);
		write_reg(CFG_STEER_HOLD, hold);
		write_reg(CFG_REVERSE_MS, rev);
		write_reg(CFG_TURN_MS, turn);
		write_reg(CFG_STUCK_MS, stuck);
		cfg_write_enable <= 1'b0;
	endtask

	// Offers one tick beat and records the command it must produce.
	task automatic offer_tick(input tick_t t, input logic use_fixed, input drive_cmd_t fixed_cmd);
		drive_cmd_t cmd;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_distance <= t.left;
		right_distance <= t.right;
		front_distance <= t.front;
		left_valid <= t.left_ok;
		right_valid <= t.right_ok;
		front_valid <= t.front_ok;
		time_ms <= t.ms;
		do @(posedge clk); while (in_stall !== 1'b0);
		cmd = predict_command(t);
		pending_cmds.push_back(use_fixed ? fixed_cmd : cmd);
	endtask

	// Stops offering and waits until every expected command has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_cmds.size() != 0);
	endtask

	// Result side: check each beat against the oldest expectation, then stall at random.
	initial begin
		drive_cmd_t want;
		int unsigned hold_left;
		int unsigned hold_off_done;
		hold_left = 0;
		hold_off_done = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_cmds.size() == 0) begin
					fault_count++;
					$error("result beat arrived with no command expected");
				end else begin
					want = pending_cmds.pop_front();
					if (motor_drive !== want.motor) begin
						fault_count++;
						$error("motor_drive: expected %0d, got %0d", want.motor, motor_drive);
					end
					if (steer_command !== want.steer) begin
						fault_count++;
						$error("steer_command: expected %0d, got %0d", want.steer, steer_command);
					end
					if (mode_now !== want.mode) begin
						fault_count++;
						$error("mode_now: expected %0d, got %0d", want.mode, mode_now);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_off_done != hold_off_asked) begin
				hold_off_done++;
				hold_left = HOLD_OFF_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		tick_t t;
		logic [15:0] stop_r;
		logic [31:0] clock_ms;
		int tgt_left;
		int tgt_right;
		int tgt_front;

		// Directed ticks: startup, blockage with wrapped time, full recovery,
		// invalid samples ignored, and a blockage stamped at time zero.
		directed_rows = '{
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd0},    1'b1, IDLE_CMD},
			'{'{13'd8191, 13'd0,    13'd0,    1'b1, 1'b1, 1'b1, 32'd2000}, 1'b1, IDLE_CMD},
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd2001}, 1'b1,
				'{PWM_HALT, STEER_LEFT, MODE_EXPLORE}},
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd999},  1'b0, IDLE_CMD},
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd1000}, 1'b0, IDLE_CMD},
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd2499}, 1'b0, IDLE_CMD},
			'{'{13'd0,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 32'd2500}, 1'b0, IDLE_CMD},
			'{'{13'd8191, 13'd8191, 13'd8191, 1'b0, 1'b0, 1'b0, 32'd2500}, 1'b0, IDLE_CMD},
			'{'{13'd8191, 13'd0,    13'd8191, 1'b1, 1'b1, 1'b1, 32'd100},  1'b0, IDLE_CMD},
			'{'{13'd8191, 13'd0,    13'd8191, 1'b1, 1'b1, 1'b1, 32'd120},  1'b0, IDLE_CMD},
			'{'{13'd8191, 13'd0,    13'd8191, 1'b1, 1'b1, 1'b1, 32'd140},  1'b0, IDLE_CMD},
			'{'{13'd0,    13'd8191, 13'd8191, 1'b1, 1'b1, 1'b1, 32'd160},  1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd0},    1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd5000}, 1'b0, IDLE_CMD},
			'{'{13'd4000, 13'd4000, 13'd0,    1'b1, 1'b1, 1'b1, 32'd8001}, 1'b0, IDLE_CMD}
		};

		// Predictor state and registers as they come out of reset.
		cfg.front_stop = CEC_RST_FRONT_STOP;
		cfg.front_slow = CEC_RST_FRONT_SLOW;
		cfg.side_min = CEC_RST_SIDE_MIN;
		cfg.deadband = CEC_RST_DEADBAND;
		cfg.hold = CEC_RST_STEER_HOLD;
		cfg.reverse_ms = CEC_RST_REVERSE_MS;
		cfg.turn_ms = CEC_RST_TURN_MS;
		cfg.stuck_ms = CEC_RST_STUCK_MS;
		ctl.avg_left = '0;
		ctl.avg_right = '0;
		ctl.avg_front = '0;
		ctl.known_left = 1'b0;
		ctl.known_right = 1'b0;
		ctl.known_front = 1'b0;
		ctl.mode = MODE_IDLE;
		ctl.blocked_since = '0;
		ctl.recover_start = '0;
		ctl.last_req = STEER_STRAIGHT;
		ctl.applied = STEER_STRAIGHT;
		ctl.repeat_count = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_tick(directed_rows[i].t, directed_rows[i].fixed_want, directed_rows[i].want);
		wait_for_results();

		clock_ms = 32'd8001;
		tgt_left = 800;
		tgt_right = 800;
		tgt_front = 2000;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase

			// Defaults, both extremes (all ones also checks width masking), then random.
			case (phase)
				0: load_settings(16'd192, 16'd320, 16'd96, 16'd48, 16'd3, 16'd1000,
					16'd1500, 16'd3000);
				1: load_settings('0, '0, '0, '0, '0, '0, '0, '0);
				2: load_settings('1, '1, '1, '1, '1, '1, '1, '1);
				default: begin
					stop_r = 16'($urandom_range(0, 600));
					load_settings(stop_r, stop_r + 16'($urandom_range(0, 600)),
						16'($urandom_range(0, 500)), 16'($urandom_range(0, 400)),
						(phase == 3) ? 16'd255 : 16'($urandom_range(1, 6)),
						16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
						16'($urandom_range(0, 3000)));
				end
			endcase

			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (phase == 0 && n == 40)
					hold_off_asked++;
				if (phase == 1 && n == 100)
					wait_for_results();

				// Occasionally the corridor changes shape around the truck.
				if ($urandom_range(24) == 0) begin
					tgt_left = $urandom_range(0, 2500);
					tgt_right = $urandom_range(0, 2500);
					tgt_front = $urandom_range(1) ? $urandom_range(0, 400) : $urandom_range(300, 8191);
				end

				if ($urandom_range(9) == 0) begin
					// Noise beat: any field value, any time stamp.
					t.left = CEC_DIST_W'($urandom_range(0, 8191));
					t.right = CEC_DIST_W'($urandom_range(0, 8191));
					t.front = CEC_DIST_W'($urandom_range(0, 8191));
					t.left_ok = 1'($urandom_range(1));
					t.right_ok = 1'($urandom_range(1));
					t.front_ok = 1'($urandom_range(1));
					t.ms = $urandom;
				end else begin
					// Plausible tick: time moves forward, readings track the corridor.
					case ($urandom_range(49))
						0: clock_ms = 32'd0;
						1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
						2, 3: clock_ms = clock_ms + $urandom_range(0, 20000);
						default: clock_ms = clock_ms + $urandom_range(0, 250);
					endcase
					t.left = near_value(tgt_left);
					t.right = near_value(tgt_right);
					t.front = near_value(tgt_front);
					t.left_ok = ($urandom_range(99) < 94);
					t.right_ok = ($urandom_range(99) < 94);
					t.front_ok = ($urandom_range(99) < 94);
					t.ms = clock_ms;
				end
				offer_tick(t, 1'b0, IDLE_CMD);
			end
			wait_for_results();
		end

		repeat (4) @(posedge clk);
		if (fault_count == 0 && pending_cmds.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
